### rtl/aigbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aigbd_pkg: shared types and constants of the AIGER binary gate decoder
// Result record, varint word, decoder control and register/status codes.
// ----------------------------------------------------------------------------
package aigbd_pkg;

  localparam int VARINT_W  = 32;          // varint payload kept to 32 bits
  localparam int LHS_OUT_W = 26;
  localparam int RHS1_W    = 33;
  localparam int RHS2_W    = 34;
  localparam int STATUS_W  = 2;
  localparam int CFG_ADDR_W = 1;

  localparam logic [7:0] PAYLOAD_MASK = 8'h7f;
  localparam int         CONT_BIT     = 7;    // bit 7 set: more bytes follow
  localparam logic [2:0] MAX_PAYLOAD_BYTES = 3'd5;

  // Result queue geometry
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;
  // Up to three results can still arrive from the staged byte and a new one
  localparam logic [RES_CNT_W-1:0] RDY_LIMIT_BUSY = RES_CNT_W'(RES_DEPTH - 3);
  localparam logic [RES_CNT_W-1:0] RDY_LIMIT_IDLE = RES_CNT_W'(RES_DEPTH - 2);

  localparam logic [CFG_ADDR_W-1:0] REG_INPUT_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_GATE_COUNT  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

  typedef struct packed {
    logic                  last;
    logic [STATUS_W-1:0]   status;
    logic [RHS2_W-1:0]     rhs2;
    logic [RHS1_W-1:0]     rhs1;
    logic [LHS_OUT_W-1:0]  lhs;
  } res_t;

  typedef struct packed {
    logic                done;   // byte closed the varint
    logic [VARINT_W-1:0] value;  // value including this byte
  } varint_t;

  typedef struct packed {
    logic restart;  // register write: start over
    logic step;     // consume the staged byte
  } dec_ctl_t;

endpackage

### rtl/aigbd_varint.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aigbd_varint: 7-bit-per-byte varint accumulator
// Adds payload from the first five bytes, truncated to 32 bits.
// ----------------------------------------------------------------------------
module aigbd_varint import aigbd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  dec_ctl_t ctl,
  input  logic [7:0] data_byte,
  output varint_t  vi
);

  logic [VARINT_W-1:0] acc_r, acc_nxt;
  logic [2:0]          pos_r, pos_nxt;
  logic [4:0]          sh;
  logic [VARINT_W-1:0] contrib;

  always_comb begin
    case (pos_r)
      3'd0: sh = 5'd0;
      3'd1: sh = 5'd7;
      3'd2: sh = 5'd14;
      3'd3: sh = 5'd21;
      3'd4: sh = 5'd28;
      default: sh = 5'd0;
    endcase
    // overlong varint: bytes past the fifth add nothing
    if (pos_r < MAX_PAYLOAD_BYTES) begin
      contrib = VARINT_W'(data_byte & PAYLOAD_MASK) << sh;
    end else begin
      contrib = '0;
    end
    vi.value = acc_r | contrib;
    vi.done  = ~data_byte[CONT_BIT];
  end

  always_comb begin
    acc_nxt = acc_r;
    pos_nxt = pos_r;
    if (ctl.restart) begin
      acc_nxt = '0;
      pos_nxt = '0;
    end else if (ctl.step) begin
      if (vi.done) begin
        acc_nxt = '0;
        pos_nxt = '0;
      end else begin
        acc_nxt = vi.value;
        if (pos_r < MAX_PAYLOAD_BYTES) begin
          pos_nxt = pos_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pos_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      pos_r <= pos_nxt;
    end
  end

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MAX_PAYLOAD_BYTES)
    else $error("varint byte position past saturation");

endmodule

### rtl/aigbd_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aigbd_gate: delta pairing, gate literals and section bookkeeping
// Holds the configuration registers and emits up to two results per byte.
// ----------------------------------------------------------------------------
module aigbd_gate import aigbd_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COUNT_BITS-1:0] cfg_data,
  input  logic                  in_v,
  input  logic                  in_eod,
  input  varint_t               vi,
  output dec_ctl_t              ctl,
  output logic [1:0]            push_n,
  output res_t                  res0,
  output res_t                  res1
);

  localparam int LHS_W = COUNT_BITS + 2;
  localparam int R1_W  = ((LHS_W > VARINT_W) ? LHS_W : VARINT_W) + 1;
  localparam int R2_W  = R1_W + 1;

  logic [COUNT_BITS-1:0]  ic_r, ic_nxt, gc_r, gc_nxt;
  logic [LHS_W-1:0]       lhs_r;
  logic [COUNT_BITS-1:0]  left_r, left_dec;
  logic                   phase_r;
  logic signed [R1_W-1:0] first_r, diff1;
  logic signed [R2_W-1:0] first_x, diff2;
  logic                   done_r;
  logic                   step, gate_v, is_last, trunc_v;
  res_t                   gate_res, trunc_res;

  assign step     = in_v && !done_r;
  assign diff1    = $signed(R1_W'(lhs_r)) - $signed(R1_W'(vi.value));
  assign first_x  = R2_W'(first_r);
  assign diff2    = first_x - $signed(R2_W'(vi.value));
  assign left_dec = left_r - COUNT_BITS'(1);
  assign is_last  = (left_dec == '0);
  assign gate_v   = step && vi.done && phase_r;
  assign trunc_v  = step && in_eod && !(gate_v && is_last);

  assign ctl.step    = step;
  assign ctl.restart = cfg_we;

  always_comb begin
    gate_res.lhs    = LHS_OUT_W'(lhs_r);
    gate_res.rhs1   = RHS1_W'(first_r);
    gate_res.rhs2   = RHS2_W'(diff2);
    gate_res.status = (first_r[R1_W-1] || diff2[R2_W-1]) ? ST_UNDER : ST_OK;
    gate_res.last   = is_last;
    trunc_res.lhs    = '0;
    trunc_res.rhs1   = '0;
    trunc_res.rhs2   = '0;
    trunc_res.status = ST_TRUNC;
    trunc_res.last   = 1'b1;
    res0   = gate_v ? gate_res : trunc_res;
    res1   = trunc_res;
    push_n = 2'(gate_v) + 2'(trunc_v);
  end

  always_comb begin
    ic_nxt = ic_r;
    gc_nxt = gc_r;
    case (cfg_addr)
      REG_INPUT_COUNT: ic_nxt = cfg_data;
      REG_GATE_COUNT:  gc_nxt = cfg_data;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r    <= '0;
      gc_r    <= '0;
      lhs_r   <= LHS_W'(2);
      left_r  <= '0;
      phase_r <= 1'b0;
      first_r <= '0;
      done_r  <= 1'b1;
    end else if (cfg_we) begin
      ic_r    <= ic_nxt;
      gc_r    <= gc_nxt;
      lhs_r   <= LHS_W'({ic_nxt, 1'b0}) + LHS_W'(2);
      left_r  <= gc_nxt;
      phase_r <= 1'b0;
      first_r <= '0;
      done_r  <= (gc_nxt == '0);
    end else if (step) begin
      if (vi.done) begin
        if (!phase_r) begin
          first_r <= diff1;
          phase_r <= 1'b1;
        end else begin
          first_r <= '0;
          phase_r <= 1'b0;
          left_r  <= left_dec;
          lhs_r   <= lhs_r + LHS_W'(2);
        end
      end
      if ((gate_v && is_last) || in_eod) begin
        done_r <= 1'b1;
      end
    end
  end

  a_quiet_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (push_n == 2'd0))
    else $error("result produced after the section ended");

  a_trunc_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (trunc_v && !cfg_we) |=> done_r)
    else $error("truncation did not close the section");

  a_lhs_even: assert property (@(posedge clk) disable iff (!rst_n)
    gate_v |-> !lhs_r[0])
    else $error("gate literal is odd");

endmodule

### rtl/aigbd_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aigbd_res_fifo: result queue
// Takes up to two results per cycle in order, gives one per cycle on pop if not empty.
// ----------------------------------------------------------------------------
module aigbd_res_fifo import aigbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_n,
  input  res_t                 res0,
  input  res_t                 res1,
  input  logic                 pop,
  output res_t                 head,
  output logic                 not_empty,
  output logic [RES_CNT_W-1:0] count
);

  res_t                 mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_r, rd_r;
  logic [RES_CNT_W-1:0] cnt_r;
  logic                 do_pop;

  assign do_pop    = pop && (cnt_r != '0);
  assign head      = mem[rd_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      mem[wr_r + RES_PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + RES_PTR_W'(push_n);
      rd_r  <= rd_r + RES_PTR_W'(do_pop);
      cnt_r <= cnt_r + RES_CNT_W'(push_n) - RES_CNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (RES_CNT_W'(push_n) + cnt_r - RES_CNT_W'(do_pop)) <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

endmodule

### rtl/aiger_binary_gate_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aiger_binary_gate_decoder_unit: binary AIGER and-gate section decoder
// Decodes delta varints byte by byte; one result per and gate or truncation.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  --------+-----------+------------------------------------------------------
//  in_     | slave     | tdata: data_byte[7:0]; tlast: end_of_data
//  out_    | master    | tdata: gate_lhs, gate_rhs1, gate_rhs2 (low bit up);
//          |           | tuser: status; tlast: last_gate
//  cfg_    | write     | addr 0: input_count, addr 1: gate_count
//
//  One byte per cycle while in_tready is high; a result is offered once its
//  byte has passed the input stage, which loads at the transfer edge, and the
//  result queue has registered the result.
//  A byte ending the data while gates remain yields a gate (if completed)
//  and then a truncation result, so a byte produces at most two results.
//  in_tready depends only on the queue fill and the input stage, never on
//  out_tready; a stalled output lets the queue fill, and in_tready drops once
//  fewer than two entries are free (three while a byte is staged).
//  Reset (rst_n low, synchronous) clears both counts; the section is then done
//  until a nonzero gate_count is written. Any register write restarts decoding.
// ----------------------------------------------------------------------------
module aiger_binary_gate_decoder_unit import aigbd_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input byte stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // end_of_data
  // gate results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [95:0]           out_tdata,  // [25:0] gate_lhs, [58:26] gate_rhs1,
                                            // [92:59] gate_rhs2, [95:93] zero
  output logic [1:0]            out_tuser,  // [1:0] status
  output logic                  out_tlast,  // last_gate
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COUNT_BITS-1:0] cfg_data
);

  logic                 in_v_r;
  logic [7:0]           byte_r;
  logic                 eod_r;
  logic                 in_xfer;
  dec_ctl_t             ctl;
  varint_t              vi;
  logic [1:0]           push_n;
  res_t                 res0, res1, head;
  logic [RES_CNT_W-1:0] q_count;

  // Leave room for everything the staged byte and a new byte can still push
  assign in_tready = in_v_r ? (q_count <= RDY_LIMIT_BUSY) : (q_count <= RDY_LIMIT_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // Input stage: register the transferred byte for decoding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r <= in_tdata;
      eod_r  <= in_tlast;
    end
  end

  aigbd_varint u_varint (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .data_byte (byte_r),
    .vi        (vi)
  );

  aigbd_gate #(
    .COUNT_BITS (COUNT_BITS)
  ) u_gate (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_v     (in_v_r),
    .in_eod   (eod_r),
    .vi       (vi),
    .ctl      (ctl),
    .push_n   (push_n),
    .res0     (res0),
    .res1     (res1)
  );

  aigbd_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .res0      (res0),
    .res1      (res1),
    .pop       (out_tready),
    .head      (head),
    .not_empty (out_tvalid),
    .count     (q_count)
  );

  // Pack the head of the queue onto the stream
  assign out_tdata = {3'b000, head.rhs2, head.rhs1, head.lhs};
  assign out_tuser = head.status;
  assign out_tlast = head.last;

  a_truncation_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_TRUNC)) |-> (out_tlast && (out_tdata == '0)))
    else $error("truncation result carries gate data");

endmodule
